/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* rtl/dsi_pkg.sv */
// ----------------------------------------------------------------------------
// dsi_pkg
// types and constants shared by the decimal string parser
// ----------------------------------------------------------------------------
package dsi_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned INDEX_W = 2;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   // register indexes of the configuration port
   typedef enum logic [INDEX_W-1:0] {
      REG_SIGNED_MODE    = 2'd0,
      REG_WIDE_MODE      = 2'd1,
      REG_FALLBACK_VALUE = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef struct packed {
      logic [VALUE_W-1:0] magnitude;
      logic               is_negative;
      logic               seen_digit;
      logic               seen_sign;
      logic               rejected;
      logic               overflowed;
   } parse_type;

   typedef struct packed {
      logic               signed_mode;
      logic               wide_mode;
      logic [VALUE_W-1:0] fallback_value;
   } config_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      status_type         status;
   } result_type;

endpackage

/* rtl/dsi_step.sv */
// ----------------------------------------------------------------------------
// dsi_step
// per-character parse update and end-of-string range check
// ----------------------------------------------------------------------------
module dsi_step (
   input  logic [dsi_pkg::CHAR_W-1:0] char_code,
   input  dsi_pkg::parse_type         parse,
   input  dsi_pkg::config_type        cfg,
   output dsi_pkg::parse_type         parse_next,
   output dsi_pkg::result_type        result
);

   logic                              is_digit;
   logic [3:0]                        digit;
   logic [dsi_pkg::VALUE_W+3:0]       times_ten;
   logic [dsi_pkg::VALUE_W+3:0]       accum;
   logic [dsi_pkg::VALUE_W-1:0]       limit;
   logic                              invalid;

   assign is_digit  = (char_code >= dsi_pkg::CHAR_ZERO) && (char_code <= dsi_pkg::CHAR_NINE);
   assign digit     = 4'(char_code - dsi_pkg::CHAR_ZERO);
   // m*10 + d over 68 bits, any carry past bit 63 is an overflow
   assign times_ten = {1'b0, parse.magnitude, 3'b000} + {3'b000, parse.magnitude, 1'b0};
   assign accum     = times_ten + {{dsi_pkg::VALUE_W{1'b0}}, digit};

   always_comb begin
      parse_next = parse;
      if (is_digit) begin
         parse_next.seen_digit = 1'b1;
         if (!parse.overflowed) begin
            if (|accum[dsi_pkg::VALUE_W+3:dsi_pkg::VALUE_W]) begin
               parse_next.overflowed = 1'b1;
            end else begin
               parse_next.magnitude = accum[dsi_pkg::VALUE_W-1:0];
            end
         end
      end else if (parse.seen_digit || parse.seen_sign) begin
         parse_next.rejected = 1'b1;
      end else if (cfg.signed_mode &&
                   (char_code == dsi_pkg::CHAR_PLUS || char_code == dsi_pkg::CHAR_MINUS)) begin
         parse_next.seen_sign   = 1'b1;
         parse_next.is_negative = (char_code == dsi_pkg::CHAR_MINUS);
      end else if (char_code != dsi_pkg::CHAR_SPACE && char_code != dsi_pkg::CHAR_TAB) begin
         parse_next.rejected = 1'b1;
      end
   end

   always_comb begin
      case ({cfg.signed_mode, cfg.wide_mode})
         2'b11:   limit = parse.is_negative ? 64'h8000_0000_0000_0000
                                            : 64'h7FFF_FFFF_FFFF_FFFF;
         2'b10:   limit = parse.is_negative ? 64'h0000_0000_8000_0000
                                            : 64'h0000_0000_7FFF_FFFF;
         2'b01:   limit = 64'hFFFF_FFFF_FFFF_FFFF;
         default: limit = 64'h0000_0000_FFFF_FFFF;
      endcase
   end

   assign invalid = parse.rejected || !parse.seen_digit ||
                    (parse.seen_sign && !cfg.signed_mode);

   always_comb begin
      result.value  = cfg.fallback_value;
      result.status = dsi_pkg::STATUS_OK;
      if (invalid) begin
         result.status = dsi_pkg::STATUS_INVALID;
      end else if (parse.overflowed || parse.magnitude > limit) begin
         result.status = dsi_pkg::STATUS_RANGE;
      end else if (cfg.signed_mode && parse.is_negative) begin
         result.value = '0 - parse.magnitude;
      end else begin
         result.value = parse.magnitude;
      end
   end

endmodule

/* rtl/decimal_string_to_integer.sv */
// ----------------------------------------------------------------------------
// decimal_string_to_integer
// streaming decimal text to 32/64-bit integer converter
// ----------------------------------------------------------------------------
// One character is taken per transaction and a new one can be taken every
// cycle: each character is held in the input register, then a single
// multiply-by-ten (shift-add), digit add and carry check updates the parse
// state. Only the NUL terminator produces a response; it is written to the
// output register from the input register, carrying the value (or the
// fallback) and a status. A terminator waits in the input register while a
// previous response is not yet taken; other characters never wait on the
// response side. Configuration is sampled when each character is processed,
// so write it only while no string is in flight.
module decimal_string_to_integer (
   input  logic        clock,
   input  logic        reset,
   // request: char_code[7:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // response: value[63:0], status[65:64], zero pad[71:66]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   // configuration write port
   input  logic        csr_we,
   input  logic [dsi_pkg::INDEX_W-1:0] csr_index,
   input  logic [63:0] csr_wdata
);

`include "assert_macros.svh"

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic [dsi_pkg::CHAR_W-1:0] char_ff;

   // parse state and configuration
   dsi_pkg::parse_type         parse_ff, parse_in, parse_next;
   dsi_pkg::config_type        cfg_ff, cfg_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   dsi_pkg::result_type        result_ff, result;

   logic                       is_end;
   logic                       out_free;
   logic                       consume;

   dsi_step u_step (
      .char_code  (char_ff),
      .parse      (parse_ff),
      .cfg        (cfg_ff),
      .parse_next (parse_next),
      .result     (result)
   );

   assign is_end     = (char_ff == dsi_pkg::CHAR_NUL);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // a terminator needs room in the output register, anything else goes on
   assign consume    = in_valid_ff && (!is_end || out_free);
   assign req_tready = !in_valid_ff || consume;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end

      // end of string hands back a clean parse state for the next one
      parse_in = parse_ff;
      if (consume) begin
         parse_in = is_end ? '0 : parse_next;
      end

      rsp_valid_in = rsp_valid_ff;
      if (consume && is_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dsi_pkg::REG_SIGNED_MODE:    cfg_in.signed_mode    = csr_wdata[0];
            dsi_pkg::REG_WIDE_MODE:      cfg_in.wide_mode      = csr_wdata[0];
            dsi_pkg::REG_FALLBACK_VALUE: cfg_in.fallback_value = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         parse_ff                 <= '0;
         cfg_ff.signed_mode       <= 1'b1;
         cfg_ff.wide_mode         <= 1'b0;
         cfg_ff.fallback_value    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         parse_ff     <= parse_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         char_ff <= req_tdata;
      end
      if (consume && is_end) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, result_ff.status, result_ff.value};

   // a processed terminator always shows up as a response next cycle
   `ASSERT_NEXT(a_end_gives_rsp, clock, reset, consume && is_end, rsp_valid_ff)
   // the parse state starts clean after a terminator
   `ASSERT_NEXT(a_end_clears_parse, clock, reset, consume && is_end,
                parse_ff == '0)
   // overflow sticks until the end of the string
   `ASSERT_NEXT(a_overflow_sticky, clock, reset,
                parse_ff.overflowed && !(consume && is_end), parse_ff.overflowed)
   // an empty output register never blocks the request side
   `ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !rsp_valid_ff, req_tready)

endmodule

/* dv/decimal_string_to_integer_checker.sv */
// ----------------------------------------------------------------------------
// decimal_string_to_integer_checker
// watches the character, response and register ports, predicts each
// conversion and compares it field by field with the response
// ----------------------------------------------------------------------------
module decimal_string_to_integer_checker
   import dsi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [CHAR_W-1:0]  req_tdata,     // char_code[7:0]
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [71:0]        rsp_tdata,     // value[63:0], status[65:64], pad
   input  logic               csr_we,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0] csr_wdata,
   output int unsigned        fail_count,
   output int unsigned        outstanding,
   output int unsigned        checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   parse_type   parse;
   config_type  modes;
   result_type  conversions_due[$];
   int unsigned failures;
   int unsigned checks;

   // advance the parse by one character, queue a conversion at the terminator
   task automatic parse_character(input logic [CHAR_W-1:0] ch);
      logic [VALUE_W-1:0] digit;
      logic [VALUE_W-1:0] limit;
      result_type         due;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         digit = VALUE_W'(ch - CHAR_ZERO);
         parse.seen_digit = 1'b1;
         if (!parse.overflowed) begin
            if (parse.magnitude > ({VALUE_W{1'b1}} - digit) / 10)
               parse.overflowed = 1'b1;
            else
               parse.magnitude = parse.magnitude * 10 + digit;
         end
      end else if (ch != CHAR_NUL) begin
         if (parse.seen_digit || parse.seen_sign) begin
            parse.rejected = 1'b1;
         end else if ((ch == CHAR_PLUS || ch == CHAR_MINUS) && modes.signed_mode) begin
            parse.seen_sign   = 1'b1;
            parse.is_negative = (ch == CHAR_MINUS);
         end else if (ch != CHAR_SPACE && ch != CHAR_TAB) begin
            parse.rejected = 1'b1;
         end
      end else begin
         due.value = modes.fallback_value;
         if (parse.rejected || !parse.seen_digit || (parse.seen_sign && !modes.signed_mode)) begin
            due.status = STATUS_INVALID;
         end else begin
            if (modes.signed_mode) begin
               limit = modes.wide_mode ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
               if (!parse.is_negative)
                  limit = limit - 1;
            end else begin
               limit = modes.wide_mode ? {VALUE_W{1'b1}} : 64'hFFFF_FFFF;
            end
            if (parse.overflowed || parse.magnitude > limit) begin
               due.status = STATUS_RANGE;
            end else begin
               due.status = STATUS_OK;
               due.value  = (modes.signed_mode && parse.is_negative) ? -parse.magnitude
                                                                     : parse.magnitude;
            end
         end
         conversions_due.push_back(due);
         parse = '0;
      end
   endtask

   always @(posedge clock) begin
      result_type         due;
      logic [VALUE_W-1:0] got_value;
      logic [1:0]         got_status;
      if (reset) begin
         parse                = '0;
         modes.signed_mode    = 1'b1;
         modes.wide_mode      = 1'b0;
         modes.fallback_value = '0;
         conversions_due.delete();
         failures = 0;
         checks   = 0;
      end else begin
         if (req_tvalid && req_tready)
            parse_character(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got_value  = rsp_tdata[63:0];
            got_status = rsp_tdata[65:64];
            if (conversions_due.size() == 0) begin
               $error("unexpected response: value %h status %0d", got_value, got_status);
               failures++;
            end else begin
               due = conversions_due.pop_front();
               checks++;
               if (got_value !== due.value) begin
                  $error("value mismatch: expected %h, actual %h", due.value, got_value);
                  failures++;
               end
               if (got_status !== due.status) begin
                  $error("status mismatch: expected %0d, actual %0d", due.status, got_status);
                  failures++;
               end
            end
         end
         // registers must only change between strings; this model does not enforce it
         if (csr_we) begin
            case (csr_index)
               REG_SIGNED_MODE:    modes.signed_mode    = csr_wdata[0];
               REG_WIDE_MODE:      modes.wide_mode      = csr_wdata[0];
               REG_FALLBACK_VALUE: modes.fallback_value = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count    <= failures;
      outstanding   <= conversions_due.size();
      checked_count <= checks;
   end

endmodule

/* dv/decimal_string_to_integer_test.sv */
// ----------------------------------------------------------------------------
// decimal_string_to_integer_test
// drives strings through the decimal parser in every sign and width mode:
// limit values, malformed text and random numbers, with random gaps on both
// ports, a long response stall and a phase without gaps
// ----------------------------------------------------------------------------
module decimal_string_to_integer_test;
   import dsi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RESET_CYCLES   = 6;
   localparam int unsigned CHAR_TARGET    = 1550;   // no new phase starts once this many characters are sent
   localparam int unsigned LINES_PER_MODE = 25;     // random strings per register setting
   localparam int unsigned IDLE_PERCENT   = 6;
   localparam int unsigned HOLD_CYCLES    = 300;    // long response stall
   localparam int unsigned SETTLE_CYCLES  = 4;      // input register plus parse stage
   localparam int unsigned DRAIN_CYCLES   = 10;
   localparam int unsigned WATCHDOG_LIMIT = 4000;   // cycles without any transaction

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [CHAR_W-1:0]  req_tdata  = '0;          // char_code[7:0]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [71:0]        rsp_tdata;                // value[63:0], status[65:64], pad[71:66]
   logic               csr_we     = 1'b0;
   logic [INDEX_W-1:0] csr_index  = REG_SIGNED_MODE;
   logic [VALUE_W-1:0] csr_wdata  = '0;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned checked_count;

   // stimulus bookkeeping
   logic [CHAR_W-1:0] line_buf[$];               // characters of the string being built
   logic              cur_signed = 1'b1;
   logic              cur_wide   = 1'b0;
   logic              quiet      = 1'b0;         // no random gaps on either side
   int unsigned       hold_requests    = 0;      // bumped to ask the receiver for a stall
   int unsigned       chars_sent       = 0;
   int unsigned       strings_sent     = 0;
   int unsigned       settings_written = 0;

   decimal_string_to_integer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   decimal_string_to_integer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // character side
   // ---------------------------------------------------------------------------

   // one character transaction; tvalid stays high afterwards so the next
   // character can follow back to back, and settle() lowers it when done
   task automatic send_char(input logic [CHAR_W-1:0] ch);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
   endtask

   // send the built string followed by its terminator
   task automatic send_line();
      foreach (line_buf[i])
         send_char(line_buf[i]);
      send_char(CHAR_NUL);
      line_buf.delete();
      strings_sent++;
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++)
         line_buf.push_back(s[i]);
      send_line();
   endtask

   // stop offering and wait until every conversion has come back, then keep
   // waiting so a trailing character cannot still be in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three registers back to back while nothing is in flight
   task automatic set_modes(input logic sm, input logic wm, input logic [VALUE_W-1:0] fb);
      settle();
      csr_we    <= 1'b1;
      csr_index <= REG_SIGNED_MODE;
      csr_wdata <= VALUE_W'(sm);
      @(posedge clock);
      csr_index <= REG_WIDE_MODE;
      csr_wdata <= VALUE_W'(wm);
      @(posedge clock);
      csr_index <= REG_FALLBACK_VALUE;
      csr_wdata <= fb;
      @(posedge clock);
      csr_we     <= 1'b0;
      cur_signed  = sm;
      cur_wide    = wm;
      settings_written++;
   endtask

   // ---------------------------------------------------------------------------
   // random string generation
   // ---------------------------------------------------------------------------

   // digit run: range edges, wide random values, small values, sometimes with
   // leading zeros or extra trailing digits that can push past 64 bits
   task automatic add_digits();
      logic [VALUE_W-1:0] mag;
      string              text;
      case ($urandom_range(9))
         0, 1: begin
            case ($urandom_range(3))
               0:       mag = 64'h7FFF_FFFF;
               1:       mag = 64'hFFFF_FFFF;
               2:       mag = 64'h7FFF_FFFF_FFFF_FFFF;
               default: mag = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            mag = mag + VALUE_W'($urandom_range(2)) - 64'd1;
         end
         2, 3, 4: mag = {$urandom, $urandom} >> $urandom_range(63);
         default: mag = VALUE_W'($urandom_range(999));
      endcase
      text = $sformatf("%0d", mag);
      if ($urandom_range(7) == 0)
         repeat ($urandom_range(3, 1)) line_buf.push_back(CHAR_ZERO);
      for (int i = 0; i < text.len(); i++)
         line_buf.push_back(text[i]);
      if ($urandom_range(11) == 0)
         repeat ($urandom_range(4, 1))
            line_buf.push_back(CHAR_ZERO + CHAR_W'($urandom_range(9)));
   endtask

   // mostly well formed numbers, some with a stray character dropped in,
   // and a few strings of arbitrary bytes
   task automatic send_random_line();
      int unsigned       kind;
      int unsigned       pos;
      logic [CHAR_W-1:0] stray;
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(5)) line_buf.push_back(CHAR_W'($urandom_range(255, 1)));
      end else begin
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(2, 1))
               line_buf.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
         if (cur_signed) begin
            case ($urandom_range(2))
               0:       ;
               1:       line_buf.push_back(CHAR_PLUS);
               default: line_buf.push_back(CHAR_MINUS);
            endcase
         end
         add_digits();
         if (kind >= 80) begin
            case ($urandom_range(4))
               0:       stray = CHAR_SPACE;
               1:       stray = CHAR_TAB;
               2:       stray = CHAR_PLUS;
               3:       stray = CHAR_MINUS;
               default: stray = CHAR_W'($urandom_range(255, 1));
            endcase
            pos = $urandom_range(line_buf.size());
            line_buf.insert(pos, stray);
         end
      end
      send_line();
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned        phase;
      logic [VALUE_W-1:0] fb;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // signed 32-bit: limits, sign and blank handling, malformed strings
      set_modes(1'b1, 1'b0, {VALUE_W{1'b1}});
      send_str("2147483647");
      send_str("-2147483648");
      send_str("2147483648");
      send_str("-2147483649");
      send_str("");                        // empty string
      send_str("-");                       // sign alone
      send_str(" \t+42");                  // leading blanks then sign
      send_str("-0");                      // minus zero is plain zero
      send_str("4 2");                     // blank after a digit
      send_str("+ 3");                     // blank after the sign
      send_str("+-1");                     // second sign
      send_str("7-");                      // sign after digits
      send_str("99999999999999999999x");   // invalid beats out of range
      line_buf.push_back(8'hFF);           // top byte value
      send_str("1");

      // unsigned 32-bit
      set_modes(1'b0, 1'b0, '0);
      send_str("4294967295");
      send_str("4294967296");
      send_str("-1");                      // sign not allowed here
      send_str("0");

      // signed 64-bit
      set_modes(1'b1, 1'b1, {$urandom, $urandom});
      send_str("9223372036854775807");
      send_str("-9223372036854775808");
      send_str("9223372036854775808");

      // unsigned 64-bit, including a magnitude past 2^64-1
      set_modes(1'b0, 1'b1, {$urandom, $urandom});
      send_str("18446744073709551615");
      send_str("18446744073709551616");
      send_str("000000000000000000000042");

      // random phases; the first four walk all mode combinations, phase 2
      // runs without gaps and phase 3 starts with a long response stall
      phase = 0;
      while (chars_sent < CHAR_TARGET) begin
         case ($urandom_range(2))
            0:       fb = '0;
            1:       fb = {VALUE_W{1'b1}};
            default: fb = {$urandom, $urandom};
         endcase
         if (phase < 4)
            set_modes(phase[0], phase[1], fb);
         else
            set_modes(1'($urandom_range(1)), 1'($urandom_range(1)), fb);
         quiet = (phase == 2);
         // the receiver stalls while strings keep coming, so the block fills
         // up and has to push back on the character side
         if (phase == 3)
            hold_requests++;
         repeat (LINES_PER_MODE) send_random_line();
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d strings, %0d characters, %0d register settings over all sign/width modes",
               strings_sent, chars_sent, settings_written);
      $display("%0d conversions checked, with a %0d-cycle response stall and a gap-free phase",
               checked_count, HOLD_CYCLES);
      if (fail_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // response side: random back-pressure, long stall on request
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned holds_served;
      int unsigned stall_left;
      holds_served = 0;
      stall_left   = 0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: too many cycles without any transaction ends the run
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned idle_run;
      idle_run = 0;
      while (idle_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
